[hw/rtl/sitoda_pkg.sv]
// shared constants and types for the signed integer to decimal text block
// no dependencies

package sitoda_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0]  CH_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'h30;
  localparam logic [DIGIT_W-1:0] DABBLE_MIN  = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD  = 4'd3;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } bcd_res_t;

endpackage

[hw/rtl/sitoda_dabble.sv]
// bit-serial binary to bcd converter (shift and add three), one bit per cycle
// depends on sitoda_pkg

module sitoda_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sitoda_pkg::VALUE_W-1:0] in_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output sitoda_pkg::bcd_res_t          res
);
  import sitoda_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_HOLD} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  bcd_t               bcd_r, bcd_nxt;
  bcd_t               bcd_adj;
  logic               neg_r, neg_nxt;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= DABBLE_MIN) ? bcd_r[i] + DABBLE_ADD : bcd_r[i];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    neg_nxt   = neg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt   = in_value[VALUE_W-1];
          mag_nxt   = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_nxt = bcd_t'({bcd_adj, mag_r[VALUE_W-1]});
        mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign in_tready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_HOLD);
  assign res.neg   = neg_r;
  assign res.bcd   = bcd_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_SHIFT && cnt_r == '0)
    else $error("transfer did not start conversion");
  a_shift_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT && cnt_r == CNT_W'(VALUE_W - 1) |=> res_valid)
    else $error("conversion did not finish after all bits");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("input taken while result pending");
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending bcd result changed");

endmodule

[hw/rtl/sitoda_emit.sv]
// character sequencer: minus sign for negative values, then significant digits, one per cycle while out_tready is high
// depends on sitoda_pkg

module sitoda_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         res_valid,
  output logic                         res_ready,
  input  sitoda_pkg::bcd_res_t         res,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [sitoda_pkg::CHAR_W-1:0] out_character,
  output logic                         out_last
);
  import sitoda_pkg::*;

  logic              have_r, have_nxt;
  logic              neg_r, neg_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  bcd_t              bcd_r, bcd_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [IDX_W-1:0]  top_idx;
  logic              load_out;

  // index of the most significant non-zero digit, zero for a zero value
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (res.bcd[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign load_out  = !out_tvalid_r || out_tready;
  assign res_ready = !have_r;

  always_comb begin
    have_nxt       = have_r;
    neg_nxt        = neg_r;
    idx_nxt        = idx_r;
    bcd_nxt        = bcd_r;
    out_tvalid_nxt = out_tvalid_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    if (load_out) begin
      out_tvalid_nxt = 1'b0;
    end
    if (!have_r) begin
      if (res_valid) begin
        have_nxt = 1'b1;
        neg_nxt  = res.neg;
        bcd_nxt  = res.bcd;
        idx_nxt  = top_idx;
      end
    end else if (load_out) begin
      out_tvalid_nxt = 1'b1;
      if (neg_r) begin
        out_char_nxt = CH_MINUS;
        out_last_nxt = 1'b0;
        neg_nxt      = 1'b0;
      end else begin
        out_char_nxt = CH_ZERO + CHAR_W'(bcd_r[idx_r]);
        out_last_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          have_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r       <= 1'b0;
      neg_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      have_r       <= have_nxt;
      neg_r        <= neg_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r      <= idx_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> have_r)
    else $error("bcd transfer not taken up");
  a_sign_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !have_r |-> !neg_r)
    else $error("minus sign pending without a number");
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    have_r && load_out && !neg_r && idx_r == '0 |=> out_tvalid && out_last && !have_r)
    else $error("final digit not flagged as last");

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// signed 32-bit integer to decimal ascii text, top level
// depends on sitoda_pkg, sitoda_dabble and sitoda_emit
//
// usage:
//   in channel: one transfer carries a two's complement 32-bit value
//   out channel: one transfer per ascii character, most significant first;
//   a '-' leads for negative values, zero gives a single '0', no leading
//   zeros; out_tlast marks the final character of each number
// conversion and throughput:
//   the value is converted to bcd one bit per cycle; the bcd result then moves
//   to the character sequencer, which registers each character it emits
//   no new value is taken while a conversion runs or its bcd result waits;
//   conversion of the next value overlaps the output of the previous one
// reset: rst_n low clears all control state; no output is pending afterwards
// stall: out_tdata and out_tlast hold while out_tready is low; conversion
//   finishes and waits, and in_tready stays low until the bcd result moves on

module signed_int_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // [31:0] value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] character
  output logic                          out_tlast
);
  import sitoda_pkg::*;

  logic     res_valid;
  logic     res_ready;
  bcd_res_t res;

  sitoda_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  sitoda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_character (out_tdata),
    .out_last      (out_tlast)
  );

endmodule
